@@ rtl/bcgd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bcgd_pkg;

    // Width of the wrapping tick clock and of all time stamps
    localparam int TIME_WIDTH = 32;
    localparam int CFG_WIDTH  = 16;
    localparam int IDX_WIDTH  = 2;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [CFG_WIDTH-1:0]  cfg_word_t;
    typedef logic [IDX_WIDTH-1:0]  cfg_idx_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
    localparam cfg_idx_t REG_LONG     = 2'd1;
    localparam cfg_idx_t REG_DOUBLE   = 2'd2;

    // Reset values of the configuration registers
    localparam cfg_word_t DEBOUNCE_RESET = 16'd2;
    localparam cfg_word_t LONG_RESET     = 16'd80;
    localparam cfg_word_t DOUBLE_RESET   = 16'd40;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SHORT  = 2'd1,
        GEST_DOUBLE = 2'd2,
        GEST_LONG   = 2'd3
    } gesture_t;

    // Timing setup shared between config block and detector
    typedef struct packed {
        cfg_word_t debounce_ticks;
        cfg_word_t long_ticks;
        cfg_word_t double_ticks;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/bcgd_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcgd_cfg_regs
    import bcgd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_valid,
    input  wire cfg_idx_t  cfg_index,
    input  wire cfg_word_t cfg_data,
    output cfg_t           cfg
);

    cfg_t cfg_reg;

    // Register file; writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.long_ticks     <= LONG_RESET;
            cfg_reg.double_ticks   <= DOUBLE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_ticks <= cfg_data;
                REG_LONG:     cfg_reg.long_ticks     <= cfg_data;
                REG_DOUBLE:   cfg_reg.double_ticks   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/bcgd_judge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcgd_judge
    import bcgd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic step,          // one sample judged this cycle
    input  wire logic raw,
    input  wire cfg_t cfg,
    output gesture_t  gesture,
    output logic      level          // debounced level after this sample
);

    time_t      clock_reg,   clock_next;
    logic       prev_reg,    prev_next;
    logic       stable_reg,  stable_next;
    time_t      change_reg,  change_next;
    time_t      press_reg,   press_next;
    time_t      release_reg, release_next;
    logic [1:0] pend_reg,    pend_next;
    logic       lfired_reg,  lfired_next;

    time_t      chg_elapsed;
    time_t      press_elapsed;
    time_t      rel_elapsed;
    logic       take;
    logic       is_double;
    logic [1:0] pend_inc;

    // Debounce, click counting and gesture decision for one tick
    always_comb begin
        clock_next   = clock_reg + time_t'(1);
        prev_next    = raw;
        change_next  = (raw != prev_reg) ? clock_next : change_reg;
        chg_elapsed  = clock_next - change_next;
        take         = (raw != stable_reg) &&
                       (chg_elapsed >= time_t'(cfg.debounce_ticks));

        stable_next  = stable_reg;
        press_next   = press_reg;
        release_next = release_reg;
        pend_next    = pend_reg;
        lfired_next  = lfired_reg;
        is_double    = 1'b0;
        pend_inc     = pend_reg + 2'd1;
        gesture      = GEST_NONE;

        if (take) begin
            stable_next = raw;
            if (raw) begin
                press_next  = clock_next;
                lfired_next = 1'b0;
            end else begin
                release_next = clock_next;
                if (lfired_reg) begin
                    // release ending a long press counts no click
                    pend_next   = 2'd0;
                    lfired_next = 1'b0;
                end else if (pend_inc >= 2'd2) begin
                    pend_next = 2'd0;
                    is_double = 1'b1;
                end else begin
                    pend_next = pend_inc;
                end
            end
        end

        press_elapsed = clock_next - press_next;
        rel_elapsed   = clock_next - release_next;

        if (is_double) begin
            gesture = GEST_DOUBLE;
        end else if (stable_next && !lfired_next && pend_next == 2'd0 &&
                     press_elapsed >= time_t'(cfg.long_ticks)) begin
            lfired_next = 1'b1;
            gesture     = GEST_LONG;
        end else if (pend_next == 2'd1 && !stable_next &&
                     rel_elapsed >= time_t'(cfg.double_ticks)) begin
            pend_next = 2'd0;
            gesture   = GEST_SHORT;
        end

        level = stable_next;
    end

    // Detector state, advanced once per judged sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg   <= '0;
            prev_reg    <= 1'b0;
            stable_reg  <= 1'b0;
            change_reg  <= '0;
            press_reg   <= '0;
            release_reg <= '0;
            pend_reg    <= 2'd0;
            lfired_reg  <= 1'b0;
        end else if (step) begin
            clock_reg   <= clock_next;
            prev_reg    <= prev_next;
            stable_reg  <= stable_next;
            change_reg  <= change_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            pend_reg    <= pend_next;
            lfired_reg  <= lfired_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/button_click_gesture_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Button gesture detector. Feed one raw button sample per timer tick on the
// s_ stream (s_tdata[0] = 1 when pressed); every sample yields exactly one
// word on the m_ stream with the gesture (none, short, double, long) and the
// debounced level after that tick. A word passes an input register and then
// the detector into an output register, and a new sample is taken every cycle
// while the output side keeps up; the detector state, updated once per
// sample, sets that rate. Timing registers are
// written on the cfg port while the stream is idle: 0 debounce, 1 long,
// 2 double (ticks, 16 bits each). Reset assumes the button is released.
module button_click_gesture_detector
    import bcgd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input samples
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [0] raw_pressed, [7:1] zero
    // gesture results
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [1:0] gesture, [2] debounced_level, [7:3] zero
    // configuration writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire cfg_idx_t   cfg_index,
    input  wire cfg_word_t  cfg_data
);

    cfg_t     cfg;
    logic     in_valid_reg;
    logic     raw_reg;
    logic     out_valid_reg;
    gesture_t gest_reg;
    logic     level_reg;
    logic     advance;
    logic     step;
    gesture_t gest_comb;
    logic     level_comb;

    assign cfg_ready = 1'b1;

    // Pipeline moves when the output register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    bcgd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcgd_judge u_judge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .raw     (raw_reg),
        .cfg     (cfg),
        .gesture (gest_comb),
        .level   (level_comb)
    );

    // Input sample register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            raw_reg <= s_tdata[0];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            gest_reg  <= gest_comb;
            level_reg <= level_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, level_reg, gest_reg};

endmodule

`default_nettype wire

@@ tb/sv/tb_button_click_gesture_detector.sv @@
`timescale 1ns / 1ps

module tb_button_click_gesture_detector;
    import bcgd_pkg::*;

    localparam int        QUIET_LIMIT = 2000;
    localparam cfg_word_t MAX_TICKS   = 16'hFFFF;
    // index with no register behind it; writes there must be ignored
    localparam cfg_idx_t  REG_SPARE   = 2'd3;

    // one result word as the block packs it: [1:0] gesture, [2] level
    typedef struct packed {
        logic     level;
        gesture_t gesture;
    } gesture_word_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_TIMING
    } row_kind_t;

    // directed script: a sample (optionally with its result typed in) or a
    // new timing setup written while the stream is idle
    typedef struct packed {
        row_kind_t kind;
        logic      raw;
        logic      typed;
        gesture_t  gesture;
        logic      level;
        cfg_word_t deb;
        cfg_word_t lng;
        cfg_word_t dbl;
    } row_t;

    localparam int SCRIPT_LEN = 29;
    localparam row_t SCRIPT [SCRIPT_LEN] = '{
        // first tick after reset, button released
        '{ROW_SAMPLE, 1'b0, 1'b1, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        // all zero: press accepted at once and long fires on that tick
        '{ROW_TIMING, 1'b0, 1'b0, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_LONG,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b0, 1'b1, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        // zero double window: short on the release tick itself
        '{ROW_TIMING, 1'b0, 1'b0, GEST_NONE,   1'b0, 16'd0, MAX_TICKS, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_NONE,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b0, 1'b1, GEST_SHORT,  1'b0, 16'd0, 16'd0, 16'd0},
        // two quick clicks
        '{ROW_TIMING, 1'b0, 1'b0, GEST_NONE,   1'b0, 16'd0, MAX_TICKS, MAX_TICKS},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_NONE,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b0, 1'b1, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_NONE,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b0, 1'b1, GEST_DOUBLE, 1'b0, 16'd0, 16'd0, 16'd0},
        // long after one tick, swallowed release, then a held press with a
        // click pending never goes long and its release is a double
        '{ROW_TIMING, 1'b0, 1'b0, GEST_NONE,   1'b0, 16'd0, 16'd1, MAX_TICKS},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_NONE,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_LONG,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b0, 1'b1, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_NONE,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b0, 1'b1, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_NONE,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_NONE,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b1, GEST_NONE,   1'b1, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b0, 1'b1, GEST_DOUBLE, 1'b0, 16'd0, 16'd0, 16'd0},
        // real debounce with a glitch on the press
        '{ROW_TIMING, 1'b0, 1'b0, GEST_NONE,   1'b0, 16'd3, 16'd4, 16'd2},
        '{ROW_SAMPLE, 1'b1, 1'b0, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b0, 1'b0, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b0, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b0, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b0, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0},
        '{ROW_SAMPLE, 1'b1, 1'b0, GEST_NONE,   1'b0, 16'd0, 16'd0, 16'd0}
    };

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_tvalid;
    logic      s_tready;
    logic [7:0] s_tdata;   // [0] raw_pressed, [7:1] zero
    logic      m_tvalid;
    logic      m_tready;
    logic [7:0] m_tdata;   // [1:0] gesture, [2] debounced_level, [7:3] zero
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_index;
    cfg_word_t cfg_data;

    button_click_gesture_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // detector image: timing setup and gesture state
    cfg_word_t deb_q  = DEBOUNCE_RESET;
    cfg_word_t long_q = LONG_RESET;
    cfg_word_t dbl_q  = DOUBLE_RESET;
    time_t     tick_count    = '0;
    logic      seen_raw      = 1'b0;
    logic      level_q       = 1'b0;
    time_t     edge_stamp    = '0;
    time_t     press_stamp   = '0;
    time_t     release_stamp = '0;
    logic [1:0] clicks       = 2'd0;
    logic      held_long     = 1'b0;

    gesture_word_t expected_gestures [$];
    int unsigned   mismatch_count = 0;
    int unsigned   samples_sent   = 0;
    int unsigned   quiet_cycles   = 0;
    bit            sender_pauses   = 1'b1;
    bit            receiver_stalls = 1'b1;

    function automatic int unsigned idle_cycles(bit enabled);
        return enabled ? $urandom_range(0, 18) : 0;
    endfunction

    // hold or gap length straddling a threshold
    function automatic int unsigned span_len(cfg_word_t ticks);
        int unsigned top;
        top = (ticks > 100) ? 100 : ticks;
        return $urandom_range(0, 1) ? $urandom_range(0, top) : top + $urandom_range(0, 4);
    endfunction

    function automatic void store_setting(cfg_idx_t idx, cfg_word_t val);
        case (idx)
            REG_DEBOUNCE: deb_q  = val;
            REG_LONG:     long_q = val;
            REG_DOUBLE:   dbl_q  = val;
            default: ;
        endcase
    endfunction

    // one tick of the gesture detector; returns the word it reports
    function automatic gesture_word_t advance_tick(logic raw);
        gesture_word_t w;
        time_t now;
        logic  doubled;
        w.gesture = GEST_NONE;
        doubled = 1'b0;
        tick_count = tick_count + 1'b1;
        now = tick_count;
        if (raw != seen_raw) begin
            seen_raw = raw;
            edge_stamp = now;
        end
        // debounced level change
        if (raw != level_q && time_t'(now - edge_stamp) >= time_t'(deb_q)) begin
            level_q = raw;
            if (level_q) begin
                press_stamp = now;
                held_long = 1'b0;
            end else begin
                release_stamp = now;
                if (held_long) begin
                    clicks = 2'd0;
                    held_long = 1'b0;
                end else begin
                    clicks = clicks + 2'd1;
                    if (clicks >= 2'd2) begin
                        clicks = 2'd0;
                        w.gesture = GEST_DOUBLE;
                        doubled = 1'b1;
                    end
                end
            end
        end
        // long hold, then quiet after a single click
        if (!doubled && level_q && !held_long && clicks == 2'd0 &&
            time_t'(now - press_stamp) >= time_t'(long_q)) begin
            held_long = 1'b1;
            w.gesture = GEST_LONG;
        end else if (!doubled && clicks == 2'd1 && !level_q &&
                     time_t'(now - release_stamp) >= time_t'(dbl_q)) begin
            clicks = 2'd0;
            w.gesture = GEST_SHORT;
        end
        w.level = level_q;
        return w;
    endfunction

    task automatic send_sample(logic raw, logic typed = 1'b0,
                               gesture_t want_g = GEST_NONE, logic want_lvl = 1'b0);
        int unsigned   gap;
        gesture_word_t predicted;
        gap = idle_cycles(sender_pauses);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, raw};
        do @(posedge aclk); while (!s_tready);
        predicted = advance_tick(raw);
        if (typed) begin
            predicted.gesture = want_g;
            predicted.level   = want_lvl;
        end
        expected_gestures.push_back(predicted);
        samples_sent++;
    endtask

    // stop the stream and let every word come out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (expected_gestures.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_timing(cfg_word_t deb, cfg_word_t lng, cfg_word_t dbl);
        cfg_idx_t  order [4];
        cfg_word_t vals [4];
        order = '{REG_DEBOUNCE, REG_LONG, REG_DOUBLE, REG_SPARE};
        vals  = '{deb, lng, dbl, cfg_word_t'($urandom)};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
            store_setting(order[k], vals[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // press and release with random bounce, sized around the current setup
    task automatic play_gesture();
        int unsigned n;
        int unsigned hold;
        int unsigned gap;
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) send_sample(1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                send_sample(1'b1);
                send_sample(1'b0);
            end
        end
        hold = deb_q + span_len(long_q);
        repeat (hold + 1) send_sample(1'b1);
        if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                send_sample(1'b0);
                send_sample(1'b1);
            end
        end
        gap = deb_q + span_len(dbl_q);
        repeat (gap + 1) send_sample(1'b0);
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial begin : drain_results
        int unsigned   stall;
        gesture_word_t want;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_cycles(receiver_stalls);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_gestures.size() == 0) begin
                $error("word with nothing expected: tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_gestures.pop_front();
                if (m_tdata[1:0] !== want.gesture) begin
                    $error("gesture: expected %0d, got %0d", want.gesture, m_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[2] !== want.level) begin
                    $error("debounced_level: expected %0d, got %0d", want.level, m_tdata[2]);
                    mismatch_count++;
                end
                if (m_tdata[7:3] !== 5'd0) begin
                    $error("pad: expected 0, got %0d", m_tdata[7:3]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        cfg_word_t   d;
        cfg_word_t   l;
        cfg_word_t   b;
        int unsigned quota;
        int unsigned target;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed script
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].kind == ROW_TIMING) begin
                hold_until_drained();
                apply_timing(SCRIPT[i].deb, SCRIPT[i].lng, SCRIPT[i].dbl);
            end else begin
                send_sample(SCRIPT[i].raw, SCRIPT[i].typed, SCRIPT[i].gesture,
                            SCRIPT[i].level);
            end
        end

        // random phases, each with its own timing setup and idle pattern
        for (int p = 0; p < 10; p++) begin
            quota = 100;
            case (p)
                0: begin
                    d = DEBOUNCE_RESET;
                    l = LONG_RESET;
                    b = DOUBLE_RESET;
                    quota = 250;
                end
                1: begin
                    d = MAX_TICKS;
                    l = MAX_TICKS;
                    b = MAX_TICKS;
                    quota = 30;
                end
                2: begin
                    d = 16'd0;
                    l = 16'd0;
                    b = 16'd0;
                end
                default: begin
                    d = cfg_word_t'($urandom_range(0, 4));
                    l = cfg_word_t'($urandom_range(0, 24));
                    b = cfg_word_t'($urandom_range(0, 16));
                end
            endcase
            hold_until_drained();
            apply_timing(d, l, b);
            sender_pauses   = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            target = samples_sent + quota;
            while (samples_sent < target) begin
                // with the longest setup nothing settles; plain noise will do
                if (p == 1)
                    send_sample(1'($urandom_range(0, 1)));
                else
                    play_gesture();
            end
        end

        hold_until_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_gestures.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
